// File: src/wgm_pkg.sv
package wgm_pkg;

  // pattern capacity in bytes
  localparam int unsigned PAT_MAX = 64;

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } wgm_cmd_t;

  // broadcast to every cell
  typedef struct packed {
    logic       en;
    wgm_cmd_t   cmd;
    logic [7:0] symbol;
  } wgm_ctl_t;

  // handed from one cell to its right neighbor
  typedef struct packed {
    logic used;  // left cell holds a pattern byte (registered)
    logic adv;   // left prefix advances on the current text byte
    logic clos;  // star closure carried from the left
  } wgm_link_t;

  typedef struct packed {
    logic pattern_overflow;
    logic matched;
  } wgm_res_t;

endpackage

// File: src/wgm_cell.sv
module wgm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               act_init,
  input  wgm_pkg::wgm_ctl_t  ctl,
  input  wgm_pkg::wgm_link_t link_in,
  output wgm_pkg::wgm_link_t link_out,
  output logic               tail
);
  import wgm_pkg::*;

  logic [7:0] byte_r;
  logic       used_r;
  logic       act_r;
  logic       act_nxt;
  logic       used_nxt;
  logic       wr;
  logic       restart;
  logic       star_eff;
  logic       star_cur;
  logic       hit;
  logic [7:0] byte_eff;

  // byte goes into the first empty cell
  assign wr       = (ctl.cmd == CMD_APPEND) && link_in.used && !used_r;
  assign restart  = (ctl.cmd != CMD_TEXT);
  assign byte_eff = wr ? ctl.symbol : byte_r;
  assign star_eff = (byte_eff == STAR_BYTE);
  assign star_cur = (byte_r == STAR_BYTE);
  assign hit      = (byte_r == QMARK_BYTE) || (byte_r == ctl.symbol);

  // next prefix state, closure ripples left to right
  always_comb begin
    if (ctl.cmd == CMD_CLEAR) begin
      used_nxt = 1'b0;
    end else begin
      used_nxt = used_r | wr;
    end
    if (restart) begin
      act_nxt = link_in.clos;
    end else begin
      act_nxt = (act_r && used_r && star_cur) || link_in.adv || link_in.clos;
    end
  end

  assign link_out.used = used_r;
  assign link_out.adv  = !restart && act_r && used_r && !star_cur && hit;
  assign link_out.clos = act_nxt && used_nxt && star_eff;

  // this prefix is the whole pattern
  assign tail = act_r && link_in.used && !used_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      act_r  <= act_init;
    end else if (ctl.en) begin
      used_r <= used_nxt;
      act_r  <= act_nxt;
    end
  end

  // pattern byte
  always_ff @(posedge clk) begin
    if (ctl.en && wr) begin
      byte_r <= ctl.symbol;
    end
  end

endmodule

// File: src/wgm_out_q.sv
module wgm_out_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wgm_pkg::wgm_res_t push_res,
  output logic              space,
  output logic              out_tvalid,
  input  logic              out_tready,
  output wgm_pkg::wgm_res_t out_res
);
  import wgm_pkg::*;

  logic     head_v_r;
  logic     skid_v_r;
  logic     head_v_nxt;
  logic     skid_v_nxt;
  wgm_res_t head_r;
  wgm_res_t skid_r;
  wgm_res_t head_nxt;
  wgm_res_t skid_nxt;
  logic     pop;

  assign pop        = head_v_r && out_tready;
  assign space      = !skid_v_r;
  assign out_tvalid = head_v_r;
  assign out_res    = head_r;

  // two-entry queue, push only while the skid entry is free
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop && skid_v_r) begin
      head_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end else if (pop || !head_v_r) begin
      head_v_nxt = push;
      head_nxt   = push_res;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// File: src/wildcard_glob_matcher.sv
// Glob matcher: clear (cmd 0), append pattern bytes (cmd 1, up to PAT_MAX, extra bytes set a
// sticky overflow flag until the next clear), stream text bytes (cmd 2), then send end of text
// (cmd 3) to get one transaction with matched and pattern_overflow; the text then restarts.
// '*' matches any run of bytes, '?' exactly one byte. A new command is accepted each cycle
// unless the output queue is full; the row of PAT_MAX cells updates all prefix states at once,
// with star closure rippling through the row like a carry chain. Results pass through a two-entry
// output queue, so input stalls only when two results are waiting. No clearing pass after reset.
module wildcard_glob_matcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic [1:0] in_tuser,   // [1:0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import wgm_pkg::*;

  wgm_ctl_t           ctl;
  wgm_link_t          link [0:PAT_MAX];
  logic [PAT_MAX-1:0] tail;
  logic [PAT_MAX-1:0] used_vec;
  logic               acc;
  logic               push;
  logic               act_end_r;
  logic               act_end_nxt;
  logic               ovf_r;
  logic               ovf_nxt;
  wgm_res_t           res;
  wgm_res_t           out_res;
  logic               space;

  assign acc        = in_tvalid && in_tready;
  assign in_tready  = space;
  assign ctl.en     = acc;
  assign ctl.cmd    = wgm_cmd_t'(in_tuser);
  assign ctl.symbol = in_tdata;
  assign push       = acc && (ctl.cmd == CMD_END);

  // left edge of the row: prefix zero is always reachable on restart
  assign link[0].used = 1'b1;
  assign link[0].adv  = 1'b0;
  assign link[0].clos = (ctl.cmd != CMD_TEXT);

  // cell row
  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    wgm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .act_init ((i == 0) ? 1'b1 : 1'b0),
      .ctl      (ctl),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .tail     (tail[i])
    );
    assign used_vec[i] = link[i+1].used;
  end

  // prefix of a full pattern and the overflow flag
  always_comb begin
    if (ctl.cmd != CMD_TEXT) begin
      act_end_nxt = link[PAT_MAX].clos;
    end else begin
      act_end_nxt = link[PAT_MAX].adv || link[PAT_MAX].clos;
    end
    case (ctl.cmd)
      CMD_CLEAR:  ovf_nxt = 1'b0;
      CMD_APPEND: ovf_nxt = ovf_r || link[PAT_MAX].used;
      default:    ovf_nxt = ovf_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_end_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (acc) begin
      act_end_r <= act_end_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // whole-pattern prefix is active
  assign res.matched          = (|tail) || (act_end_r && link[PAT_MAX].used);
  assign res.pattern_overflow = ovf_r;

  wgm_out_q u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_res   (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {6'd0, out_res.pattern_overflow, out_res.matched};

`ifndef SYNTHESIS
  // stored pattern bytes stay contiguous from cell zero
  a_used_contig: assert property (@(posedge clk) disable iff (!rst_n)
    ((used_vec >> 1) & ~used_vec) == '0)
    else $error("pattern cells not contiguous");

  // overflow only rises on an append into a full row
  a_ovf_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(acc && (ctl.cmd == CMD_APPEND) && link[PAT_MAX].used))
    else $error("overflow set without a dropped byte");

  // a new result shows up only after an end-of-text transaction
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(push))
    else $error("result without end of text");

  // input back-pressure only with results waiting
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // at most one prefix marks the whole pattern
  a_tail_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tail))
    else $error("multiple pattern tails");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import wgm_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 16;
  localparam int ITEM_TARGET = 1500;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] symbol
  logic [1:0] in_tuser;   // [1:0] cmd
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] matched, [1] pattern_overflow, [7:2] zero

  wildcard_glob_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // directed row: command, symbol, and a hand-written verdict where one is given
  typedef struct packed {
    wgm_cmd_t   cmd;
    logic [7:0] sym;
    logic       typed;
    logic       matched;
    logic       overflow;
  } glob_row_t;

  localparam int DIRECTED_ROWS = 25;
  glob_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_END,    8'h00,      1'b1, 1'b1, 1'b0},  // empty pattern, empty text
    '{CMD_TEXT,   8'h00,      1'b0, 1'b0, 1'b0},
    '{CMD_END,    8'h00,      1'b1, 1'b0, 1'b0},  // empty pattern, one byte of text
    '{CMD_APPEND, 8'hFF,      1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   8'hFF,      1'b0, 1'b0, 1'b0},
    '{CMD_END,    8'h00,      1'b1, 1'b1, 1'b0},  // literal byte matches itself
    '{CMD_APPEND, STAR_BYTE,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   8'hFF,      1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   8'h00,      1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   STAR_BYTE,  1'b0, 1'b0, 1'b0},
    '{CMD_END,    8'h00,      1'b0, 1'b0, 1'b0},
    '{CMD_CLEAR,  8'hFF,      1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, QMARK_BYTE, 1'b0, 1'b0, 1'b0},
    '{CMD_END,    8'h00,      1'b1, 1'b0, 1'b0},  // '?' needs one byte
    '{CMD_TEXT,   QMARK_BYTE, 1'b0, 1'b0, 1'b0},
    '{CMD_END,    8'h00,      1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, STAR_BYTE,  1'b0, 1'b0, 1'b0},
    '{CMD_END,    8'hFF,      1'b0, 1'b0, 1'b0},
    '{CMD_CLEAR,  8'h00,      1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, STAR_BYTE,  1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, STAR_BYTE,  1'b0, 1'b0, 1'b0},
    '{CMD_END,    8'h00,      1'b1, 1'b1, 1'b0},  // stars only, empty text
    '{CMD_END,    8'hFF,      1'b1, 1'b1, 1'b0},  // text restarted after end
    '{CMD_TEXT,   8'h41,      1'b0, 1'b0, 1'b0},
    '{CMD_END,    8'h00,      1'b0, 1'b0, 1'b0}
  };

  // glob state mirror
  logic [7:0]       pat_bytes [PAT_MAX];
  int unsigned      pat_len;
  logic [PAT_MAX:0] live_prefixes;
  logic             pat_dropped;

  wgm_res_t pending_verdicts [$];
  int       errors;
  int       items_sent;
  int       burst_left;
  bit       no_gaps;
  bit       hold_req;
  int       idle_cycles;
  wgm_res_t got_verdict;
  wgm_res_t want_verdict;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // star closure over the stored pattern
  function automatic logic [PAT_MAX:0] close_stars(input logic [PAT_MAX:0] prefixes);
    for (int i = 0; i < pat_len; i++) begin
      if (prefixes[i] && pat_bytes[i] == STAR_BYTE) prefixes[i+1] = 1'b1;
    end
    return prefixes;
  endfunction

  function automatic logic [PAT_MAX:0] fresh_text();
    logic [PAT_MAX:0] start;
    start    = '0;
    start[0] = 1'b1;
    return close_stars(start);
  endfunction

  // advance the glob state by one transaction
  task automatic predict_glob(input wgm_cmd_t cmd, input logic [7:0] sym,
                              output bit emits, output wgm_res_t verdict);
    logic [PAT_MAX:0] next_prefixes;
    emits   = 1'b0;
    verdict = '0;
    case (cmd)
      CMD_CLEAR: begin
        pat_len       = 0;
        pat_dropped   = 1'b0;
        live_prefixes = fresh_text();
      end
      CMD_APPEND: begin
        if (pat_len < PAT_MAX) begin
          pat_bytes[pat_len] = sym;
          pat_len++;
        end else begin
          pat_dropped = 1'b1;
        end
        live_prefixes = fresh_text();
      end
      CMD_TEXT: begin
        next_prefixes = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (live_prefixes[i]) begin
            if (pat_bytes[i] == STAR_BYTE) next_prefixes[i] = 1'b1;
            else if (pat_bytes[i] == QMARK_BYTE || pat_bytes[i] == sym)
              next_prefixes[i+1] = 1'b1;
          end
        end
        live_prefixes = close_stars(next_prefixes);
      end
      default: begin
        emits                    = 1'b1;
        verdict.matched          = live_prefixes[pat_len];
        verdict.pattern_overflow = pat_dropped;
        live_prefixes            = fresh_text();
      end
    endcase
  endtask

  // offer one transaction, with bursts and gaps, and record its verdict
  task automatic send_item(input wgm_cmd_t cmd, input logic [7:0] sym,
                           input bit typed, input wgm_res_t typed_verdict);
    int       gap;
    bit       emits;
    wgm_res_t verdict;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= sym;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    predict_glob(cmd, sym, emits, verdict);
    if (emits) pending_verdicts.push_back(typed ? typed_verdict : verdict);
    items_sent++;
  endtask

  task automatic send_plain(input wgm_cmd_t cmd, input logic [7:0] sym);
    send_item(cmd, sym, 1'b0, '0);
  endtask

  // hold the input low until every verdict has come back
  task automatic drain_verdicts();
    if (pending_verdicts.size() != 0) begin
      in_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pattern_byte();
    case ($urandom_range(0, 7))
      0, 1:    return "a";
      2:       return "b";
      3:       return "c";
      4, 5:    return STAR_BYTE;
      6:       return QMARK_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 7))
      0, 1, 2: return "a";
      3:       return "b";
      4:       return "c";
      5:       return STAR_BYTE;
      6:       return QMARK_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // load a fresh pattern, then stream texts built to match it, some of them mutated
  task automatic run_glob_case(input bit fill_store);
    int         plen;
    int         ntexts;
    int         pos;
    logic [7:0] b;
    logic [7:0] stored [$];
    logic [7:0] text [$];
    if (fill_store || $urandom_range(0, 11) == 0) plen = $urandom_range(PAT_MAX - 2, PAT_MAX + 3);
    else plen = $urandom_range(0, 8);
    if (fill_store) plen = PAT_MAX + 2;
    send_plain(CMD_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < plen; i++) begin
      b = pattern_byte();
      if (stored.size() < PAT_MAX) stored.push_back(b);
      send_plain(CMD_APPEND, b);
    end
    ntexts = $urandom_range(1, 4);
    for (int t = 0; t < ntexts; t++) begin
      text.delete();
      foreach (stored[j]) begin
        if (stored[j] == STAR_BYTE) repeat ($urandom_range(0, 3)) text.push_back(text_byte());
        else if (stored[j] == QMARK_BYTE) text.push_back(text_byte());
        else text.push_back(stored[j]);
      end
      // occasional corruption of the text
      if ($urandom_range(0, 2) == 0) begin
        pos = (text.size() == 0) ? 0 : $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 2))
          0: if (text.size() != 0) text[pos] = text_byte();
          1: if (text.size() != 0) text.delete(pos);
          default: text.insert(pos, text_byte());
        endcase
      end
      foreach (text[j]) send_plain(CMD_TEXT, text[j]);
      send_plain(CMD_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // stimulus
  initial begin
    wgm_res_t typed_verdict;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    errors        = 0;
    items_sent    = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    pat_len       = 0;
    pat_dropped   = 1'b0;
    live_prefixes = '0;
    live_prefixes[0] = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      typed_verdict.matched          = directed_rows[r].matched;
      typed_verdict.pattern_overflow = directed_rows[r].overflow;
      send_item(directed_rows[r].cmd, directed_rows[r].sym, directed_rows[r].typed,
                typed_verdict);
    end
    drain_verdicts();

    // full store with dropped bytes
    run_glob_case(1'b1);

    // receiver holds off while the sender keeps offering ends of text
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (10) begin
      send_plain(CMD_TEXT, text_byte());
      send_plain(CMD_END, 8'($urandom_range(0, 255)));
    end
    no_gaps = 1'b0;
    drain_verdicts();

    // random part: mostly well-formed cases, some noise
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6))
          send_plain(wgm_cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        run_glob_case(1'b0);
      end
      if ($urandom_range(0, 9) == 0) drain_verdicts();
    end

    // wind down
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  // result receiver: random ready phases, plus one long hold on request
  initial begin
    int mode;
    int phase_left;
    out_tready = 1'b0;
    mode       = 0;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 3);
          phase_left = $urandom_range(10, 80);
        end
        phase_left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 4) == 0);
          default: out_tready <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_verdict = wgm_res_t'(out_tdata[1:0]);
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result transaction: out_tdata %0h", out_tdata);
        errors++;
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (got_verdict.matched !== want_verdict.matched) begin
          $error("matched: expected %0b, actual %0b", want_verdict.matched,
                 got_verdict.matched);
          errors++;
        end
        if (got_verdict.pattern_overflow !== want_verdict.pattern_overflow) begin
          $error("pattern_overflow: expected %0b, actual %0b",
                 want_verdict.pattern_overflow, got_verdict.pattern_overflow);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule

// File: wildcard_glob_matcher.f
src/wgm_pkg.sv
src/wgm_cell.sv
src/wgm_out_q.sv
src/wildcard_glob_matcher.sv
dv/testbench.sv
